// ===== design/radix_integer_to_ascii_defines.svh =====
// Assertion macros shared by the checker of the radix integer to ASCII block.
// No dependencies; included by the files that hold concurrent assertions.
`ifndef RADIX_INTEGER_TO_ASCII_DEFINES_SVH
`define RADIX_INTEGER_TO_ASCII_DEFINES_SVH

// Checked on every clock edge outside reset.
`define RIA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RIA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ria_pkg.sv =====
// Package of the radix integer to ASCII block: constants, command and status types.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package ria_pkg;

  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;

  localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [DIGIT_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'd48;  // '0'
  localparam logic [CHAR_W-1:0]  CHAR_A      = 7'd97;  // 'a'
  localparam logic [DIGIT_W-1:0] DIGIT_NINE  = 6'd9;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 6'd10;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // latch a new value and clear the digit count
    logic step;   // one bit of the long division
    logic store;  // write the remainder as a digit and restart the division
    logic read;   // read one digit for output, most significant first
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;   // this division step is the last one of a digit
    logic quot_zero;  // the quotient left after a digit is zero
    logic rd_last;    // the digit being read is the least significant
  } dp_status_t;

  // Digit value to lower-case ASCII.
  function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d > DIGIT_NINE) begin
      c = CHAR_A + {1'b0, d - DIGIT_TEN};
    end else begin
      c = CHAR_ZERO + {1'b0, d};
    end
    return c;
  endfunction

endpackage

// ===== design/ria_ctrl.sv =====
// Controller of the radix integer to ASCII block: sequences division, storing and output.
// Depends on ria_pkg for the command and status types.
`timescale 1ns / 1ps

module ria_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  ria_pkg::dp_status_t    status,
  output ria_pkg::ctrl_cmd_t     cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIVIDE,
    S_STORE,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DIVIDE;
      end
      S_DIVIDE: begin
        if (status.div_done) state_nxt = S_STORE;
      end
      S_STORE: begin
        state_nxt = status.quot_zero ? S_EMIT : S_DIVIDE;
      end
      S_EMIT: begin
        if (status.rd_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  // Commands follow the current state.
  always_comb begin
    cmd.load  = (state_r == S_IDLE) && start;
    cmd.step  = (state_r == S_DIVIDE);
    cmd.store = (state_r == S_STORE);
    cmd.read  = (state_r == S_EMIT);
  end

  // State and registered busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

// ===== design/ria_datapath.sv =====
// Datapath of the radix integer to ASCII block: radix register, bit-serial divider,
// digit memory and output register. Depends on ria_pkg.
`timescale 1ns / 1ps

module ria_datapath #(
  parameter int W = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [ria_pkg::DIGIT_W-1:0]  cfg_radix,
  input  logic [W-1:0]                 value,
  input  ria_pkg::ctrl_cmd_t           cmd,
  output ria_pkg::dp_status_t          status,
  output logic                         out_valid,
  output logic [ria_pkg::CHAR_W-1:0]   out_char,
  output logic                         out_last
);

  localparam int IDX_W = (W > 1) ? $clog2(W) : 1;
  localparam logic [IDX_W-1:0] LAST_BIT = IDX_W'(W - 1);
  localparam int DW = ria_pkg::DIGIT_W;

  logic [DW-1:0]    radix_r;
  logic [W-1:0]     quot_r;
  logic [DW-1:0]    rem_r;
  logic [IDX_W-1:0] bit_cnt_r;
  logic [IDX_W-1:0] cnt_r;
  logic [IDX_W-1:0] rd_ptr_r;
  logic [DW-1:0]    rd_data_r;
  logic             out_valid_r;
  logic             out_last_r;
  logic [DW-1:0]    mem [W];

  logic [DW:0]      trial;
  logic             ge;
  logic [DW:0]      diff;
  logic [DW-1:0]    rem_nxt;
  logic [DW-1:0]    radix_nxt;

  // Clamp the written radix into its legal range.
  always_comb begin
    priority if (cfg_radix < ria_pkg::RADIX_MIN) begin
      radix_nxt = ria_pkg::RADIX_MIN;
    end else if (cfg_radix > ria_pkg::RADIX_MAX) begin
      radix_nxt = ria_pkg::RADIX_MAX;
    end else begin
      radix_nxt = cfg_radix;
    end
  end

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    trial   = {rem_r, quot_r[W-1]};
    ge      = (trial >= {1'b0, radix_r});
    diff    = trial - {1'b0, radix_r};
    rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_comb begin
    status.div_done  = (bit_cnt_r == LAST_BIT);
    status.quot_zero = (quot_r == '0);
    status.rd_last   = (rd_ptr_r == '0);
  end

  // Radix register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= ria_pkg::RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= radix_nxt;
    end
  end

  // Divider and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_cnt_r <= '0;
      cnt_r     <= '0;
      rd_ptr_r  <= '0;
    end else begin
      if (cmd.load) begin
        bit_cnt_r <= '0;
        cnt_r     <= '0;
      end else if (cmd.step) begin
        bit_cnt_r <= bit_cnt_r + 1'b1;
      end else if (cmd.store) begin
        bit_cnt_r <= '0;
        cnt_r     <= cnt_r + 1'b1;
        rd_ptr_r  <= cnt_r;
      end else if (cmd.read) begin
        rd_ptr_r  <= rd_ptr_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quot_r <= value;
      rem_r  <= '0;
    end else if (cmd.step) begin
      quot_r <= {quot_r[W-2:0], ge};
      rem_r  <= rem_nxt;
    end else if (cmd.store) begin
      rem_r  <= '0;
    end
  end

  // Digit memory, least significant digit at address zero.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[cnt_r] <= rem_r;
    end
    if (cmd.read) begin
      rd_data_r  <= mem[rd_ptr_r];
      out_last_r <= status.rd_last;
    end
  end

  // Output strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.read;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = ria_pkg::to_ascii(rd_data_r);
  assign out_last  = out_last_r;

endmodule

// ===== design/radix_integer_to_ascii.sv =====
// Top level of the radix integer to ASCII block: controller plus datapath.
// Depends on ria_pkg, ria_ctrl and ria_datapath.
`timescale 1ns / 1ps

// Converts one unsigned value per request into ASCII digits in the configured radix.
// Input: a request is taken when start is high and busy is low; in_value is sampled
//   then, and only its low VALUE_BITS bits are used.
// Configuration: cfg_valid with cfg_radix writes the radix (clamped to 2..36);
//   cfg_ready is always high. Write it only while the block is idle.
// Output: each digit appears for exactly one cycle with out_valid high, most
//   significant first, lower-case letters above nine; out_last_digit marks the
//   final digit. The receiver cannot stall, so no result is ever held back.
// Operation: each digit takes VALUE_BITS steps of the bit-serial restoring divider
//   and is then stored in the digit memory; once all digits are stored they leave
//   one per cycle from the digit memory. Zero converts as a single digit.
// Reset: rst_n low at a clock edge returns the controller to idle, drops out_valid
//   and sets the radix to ten.
module radix_integer_to_ascii #(
  parameter int VALUE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_value,
  output logic        out_valid,
  output logic [6:0]  out_digit_char,
  output logic        out_last_digit,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_radix
);

  ria_pkg::ctrl_cmd_t  cmd;
  ria_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  ria_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  ria_datapath #(
    .W (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_radix (cfg_radix),
    .value     (in_value[VALUE_BITS-1:0]),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_char  (out_digit_char),
    .out_last  (out_last_digit)
  );

endmodule

// ===== design/ria_checker.sv =====
// Port-level checker of the radix integer to ASCII block, bound to the top level.
// Depends on radix_integer_to_ascii_defines.svh for the assertion macros and ria_pkg.
`timescale 1ns / 1ps
`include "radix_integer_to_ascii_defines.svh"

module ria_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [6:0]  out_digit_char,
  input logic        out_last_digit
);

  logic char_ok;

  // A digit character is 0 to 9 or a lower-case letter up to z.
  assign char_ok =
    ((out_digit_char >= ria_pkg::CHAR_ZERO) && (out_digit_char <= ria_pkg::CHAR_ZERO + 7'd9)) ||
    ((out_digit_char >= ria_pkg::CHAR_A) && (out_digit_char <= ria_pkg::CHAR_A + 7'd25));

  // Reset leaves the block idle with no digit on the output.
  `RIA_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> (!busy && !out_valid), "reset not idle")

  // An accepted request makes the block busy.
  `RIA_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "request not taken")

  // Digits only come out of a conversion in progress.
  `RIA_ASSERT(a_out_in_work, clk, rst_n, out_valid |-> $past(busy), "digit while idle")

  // Every digit is a legal ASCII digit or lower-case letter.
  `RIA_ASSERT(a_char_legal, clk, rst_n, out_valid |-> char_ok, "bad digit")

  // Nothing follows the final digit of a number at once.
  `RIA_ASSERT(a_last_ends, clk, rst_n, (out_valid && out_last_digit) |=> !out_valid, "digit after last")

endmodule

bind radix_integer_to_ascii ria_checker u_ria_checker (.*);
